@@ rtl/tfh_pkg.sv @@
// shared types and constants for the toeplitz flow hash
// no dependencies; imported by tfh_hash_pipe, toeplitz_flow_hash and the testbench
`timescale 1ns / 1ps

package tfh_pkg;

  localparam int KEY_BYTES_DEF = 40;
  localparam int KEY_BYTES_MIN = 4;
  localparam int KEY_BYTES_MAX = 40;
  localparam int KEY_REGS      = 5;
  localparam int KEY_REG_W     = 64;
  localparam int KEY_FLAT_W    = KEY_REGS * KEY_REG_W;
  localparam int TUPLE_BITS    = 96;
  localparam int HASH_W        = 32;
  localparam int IN_DATA_W     = 128;
  localparam int CFG_ADDR_W    = 6;
  localparam int CFG_DATA_W    = 64;

  typedef logic [HASH_W-1:0] hash_t;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_KEY4 = 3'd4
  } reg_idx_t;

endpackage

@@ rtl/tfh_hash_pipe.sv @@
// three-stage xor tree of key windows selected by the tuple bits
// depends on tfh_pkg
`timescale 1ns / 1ps

module tfh_hash_pipe #(
  parameter int KEY_BYTES = tfh_pkg::KEY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tfh_pkg::KEY_FLAT_W-1:0] key_flat,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tfh_pkg::TUPLE_BITS-1:0] in_tuple,
  input  tfh_pkg::hash_t                in_seed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tfh_pkg::hash_t                out_hash
);
  import tfh_pkg::*;

  localparam int KB_EFF     = (KEY_BYTES < KEY_BYTES_MIN) ? KEY_BYTES_MIN :
                              ((KEY_BYTES > KEY_BYTES_MAX) ? KEY_BYTES_MAX : KEY_BYTES);
  localparam int KEY_BITS   = 8 * KB_EFF;
  localparam int GROUP_BITS = 6;
  localparam int GROUPS     = TUPLE_BITS / GROUP_BITS;
  localparam int MID        = 4;
  localparam int MID_FAN    = GROUPS / MID;

  hash_t win [TUPLE_BITS];

  // window p bit k is key bit (p+k) mod key length, msb first
  for (genvar p = 0; p < TUPLE_BITS; p++) begin : g_win
    for (genvar k = 0; k < HASH_W; k++) begin : g_bit
      localparam int Q = (p + k) % KEY_BITS;
      assign win[p][HASH_W-1-k] = key_flat[KEY_FLAT_W-1-Q];
    end
  end

  logic  v1_r, v2_r, vo_r;
  logic  en1, en2, en3;
  hash_t part1_r [GROUPS];
  hash_t part1_nxt [GROUPS];
  hash_t seed1_r, seed2_r;
  hash_t part2_r [MID];
  hash_t part2_nxt [MID];
  hash_t hash_r, hash_nxt;

  assign en3      = !vo_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part1_nxt[g] = '0;
      for (int j = 0; j < GROUP_BITS; j++) begin
        if (in_tuple[TUPLE_BITS-1-(g*GROUP_BITS+j)]) begin
          part1_nxt[g] = part1_nxt[g] ^ win[g*GROUP_BITS+j];
        end
      end
    end
  end

  always_comb begin
    for (int m = 0; m < MID; m++) begin
      part2_nxt[m] = '0;
      for (int i = 0; i < MID_FAN; i++) begin
        part2_nxt[m] = part2_nxt[m] ^ part1_r[m*MID_FAN+i];
      end
    end
  end

  always_comb begin
    hash_nxt = seed2_r;
    for (int m = 0; m < MID; m++) begin
      hash_nxt = hash_nxt ^ part2_r[m];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) vo_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      part1_r <= part1_nxt;
      seed1_r <= in_seed;
    end
    if (en2 && v1_r) begin
      part2_r <= part2_nxt;
      seed2_r <= seed1_r;
    end
    if (en3 && v2_r) begin
      hash_r <= hash_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_hash  = hash_r;

`ifndef NO_ASSERTIONS
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !en2 |=> v1_r)
    else $error("stage 1 beat dropped while stalled");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && vo_r && !out_ready)
    else $error("input stalled with a bubble in the pipe");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && en3 |=> vo_r)
    else $error("stage 2 beat lost on its way to the output");
`endif

endmodule

@@ rtl/toeplitz_flow_hash.sv @@
// toeplitz flow hash top level: apb key registers and stream channels
// depends on tfh_pkg and tfh_hash_pipe
`timescale 1ns / 1ps

// usage
// input stream: one beat per flow carries src_addr, dst_addr, src_port,
//   dst_port and seed in in_tdata; the hash of that tuple leaves as one
//   beat on the output stream, in order
// apb port: five 64-bit key registers at byte addresses 0, 8 .. 32, key
//   byte 0 in the top bits of key_word0; writes take setup and access
//   cycles, pready is always high, reads return the stored value
// the user must change the key only while no beat is in flight; the block does not enforce this
// pipeline: an accepted beat passes the part1, part2 and hash registers in turn
//   (three stages) before it is valid on the output and can leave
// throughput: one beat per cycle, limited only by the output handshake
// stall: when out_tready is low the pipe fills up and in_tready falls once
//   all three stages hold a beat; nothing is lost or repeated
// reset: synchronous rst_n clears the pipe valid bits and the key to zero
module toeplitz_flow_hash #(
  parameter int KEY_BYTES = tfh_pkg::KEY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // src_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80],
  // seed[127:96]
  input  logic [tfh_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // hash[31:0]
  output logic [tfh_pkg::HASH_W-1:0]     out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tfh_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tfh_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tfh_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import tfh_pkg::*;

  logic [KEY_REG_W-1:0]   key_r [KEY_REGS];
  logic [KEY_FLAT_W-1:0]  key_flat;
  logic [TUPLE_BITS-1:0]  tuple;
  reg_idx_t               reg_idx;
  logic                   wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY0: key_r[0] <= cfg_pwdata;
        REG_KEY1: key_r[1] <= cfg_pwdata;
        REG_KEY2: key_r[2] <= cfg_pwdata;
        REG_KEY3: key_r[3] <= cfg_pwdata;
        REG_KEY4: key_r[4] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY0: cfg_prdata = key_r[0];
      REG_KEY1: cfg_prdata = key_r[1];
      REG_KEY2: cfg_prdata = key_r[2];
      REG_KEY3: cfg_prdata = key_r[3];
      REG_KEY4: cfg_prdata = key_r[4];
      default:  cfg_prdata = '0;
    endcase
  end

  // key_word0 first, so key bit q sits at key_flat[top - q]
  for (genvar i = 0; i < KEY_REGS; i++) begin : g_key
    assign key_flat[KEY_FLAT_W-1-i*KEY_REG_W -: KEY_REG_W] = key_r[i];
  end

  // tuple bit 0 is the top bit of src_addr
  assign tuple = {in_tdata[31:0], in_tdata[63:32], in_tdata[79:64], in_tdata[95:80]};

  tfh_hash_pipe #(
    .KEY_BYTES (KEY_BYTES)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_flat  (key_flat),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_tuple  (tuple),
    .in_seed   (in_tdata[127:96]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hash  (out_tdata)
  );

endmodule

@@ tb/tb_toeplitz_flow_hash.sv @@
// self-checking testbench for toeplitz_flow_hash: flow beats with random bursts,
// receiver stalls and apb key loads, each hash checked against an in-bench predictor
// depends on tfh_pkg and toeplitz_flow_hash
`timescale 1ns / 1ps

module tb_toeplitz_flow_hash;
  import tfh_pkg::*;

  localparam int KEY_BYTES_EFF = (KEY_BYTES_DEF < KEY_BYTES_MIN) ? KEY_BYTES_MIN :
                                 (KEY_BYTES_DEF > KEY_BYTES_MAX) ? KEY_BYTES_MAX :
                                 KEY_BYTES_DEF;
  localparam int KEY_BITS_EFF  = 8 * KEY_BYTES_EFF;
  localparam int ADDR_SLOTS    = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int FLOWS_PER_KEY = 110;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b1;
  logic [HASH_W-1:0]     out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic [KEY_REG_W-1:0]  key_shadow [KEY_REGS];
  logic [IN_DATA_W-1:0]  flows_pending [$];
  hash_t                 hashes_due [$];

  int errors       = 0;
  int flows_hashed = 0;
  int key_loads    = 0;
  int reg_writes   = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int seg_left     = 0;
  int stall_pct    = 0;
  int hold_cnt     = 0;
  int holds_asked  = 0;
  int holds_done   = 0;
  int idle_cycles  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  toeplitz_flow_hash DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  function automatic hash_t toeplitz_hash(input logic [IN_DATA_W-1:0] beat);
    logic [TUPLE_BITS-1:0] tuple;
    hash_t acc;
    hash_t window;
    int q;
    int byte_i;
    tuple = {beat[31:0], beat[63:32], beat[79:64], beat[95:80]};
    acc = beat[127:96];
    for (int p = 0; p < TUPLE_BITS; p++) begin
      if (tuple[TUPLE_BITS-1-p]) begin
        window = '0;
        for (int k = 0; k < HASH_W; k++) begin
          q = (p + k) % KEY_BITS_EFF;
          byte_i = q / 8;
          window = {window[HASH_W-2:0], key_shadow[byte_i/8][63 - 8*(byte_i%8) - q%8]};
        end
        acc ^= window;
      end
    end
    return acc;
  endfunction

  function automatic logic [IN_DATA_W-1:0] flow_beat(input logic [TUPLE_BITS-1:0] t,
                                                     input hash_t seed);
    return {seed, t[15:0], t[31:16], t[63:32], t[95:64]};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (flows_pending.size() != 0) begin
        in_tdata  <= flows_pending.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: segments of random stall density, plus requested long hold-offs
  always @(posedge clk) begin
    if (holds_done != holds_asked) begin
      out_tready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_cnt   <= 0;
        holds_done <= holds_done + 1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end else if (seg_left == 0) begin
      seg_left   <= $urandom_range(4, 64);
      out_tready <= 1'b1;
      case ($urandom_range(0, 4))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 25;
        3:       stall_pct <= 50;
        default: stall_pct <= 90;
      endcase
    end else begin
      seg_left   <= seg_left - 1;
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: predict on input beats, compare on output beats
  always @(posedge clk) begin : monitor
    hash_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (hashes_due.size() == 0) begin
          report_mismatch("hash beat with no flow pending", 64'(out_tdata), 64'(0));
        end else begin
          want = hashes_due.pop_front();
          if (out_tdata !== want) report_mismatch("hash", 64'(out_tdata), 64'(want));
        end
      end
      if (in_tvalid && in_tready) begin
        hashes_due.push_back(toeplitz_hash(in_tdata));
        flows_hashed++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("no beat moved for %0d cycles", IDLE_LIMIT);
      $display("toeplitz_flow_hash regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input int idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(8 * idx);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx < KEY_REGS) key_shadow[idx] = data;
    reg_writes++;
  endtask

  task automatic apb_read(input int idx, output logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(8 * idx);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_key_regs();
    logic [CFG_DATA_W-1:0] rd;
    for (int i = REG_KEY0; i <= REG_KEY4; i++) begin
      apb_read(i, rd);
      if (rd !== key_shadow[i]) report_mismatch($sformatf("key_word%0d readback", i),
                                                rd, key_shadow[i]);
    end
  endtask

  // word i of the key sits at flat[64*i +: 64]
  task automatic load_key(input logic [KEY_FLAT_W-1:0] flat);
    for (int i = REG_KEY0; i <= REG_KEY4; i++) apb_write(i, flat[KEY_REG_W*i +: KEY_REG_W]);
    check_key_regs();
    key_loads++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (flows_pending.size() != 0 || in_tvalid || hashes_due.size() != 0);
  endtask

  task automatic queue_directed();
    flows_pending.push_back(flow_beat('0, '0));
    flows_pending.push_back(flow_beat('0, '1));
    flows_pending.push_back(flow_beat('1, '0));
    flows_pending.push_back(flow_beat('1, '1));
    flows_pending.push_back(flow_beat(96'd1 << 95, 32'h0));
    flows_pending.push_back(flow_beat(96'd1 << 64, 32'h0));
    flows_pending.push_back(flow_beat(96'd1 << 63, 32'h0));
    flows_pending.push_back(flow_beat(96'd1 << 32, 32'h0));
    flows_pending.push_back(flow_beat(96'd1 << 31, 32'h0));
    flows_pending.push_back(flow_beat(96'd1 << 16, 32'h0));
    flows_pending.push_back(flow_beat(96'd1 << 15, 32'h0));
    flows_pending.push_back(flow_beat(96'd1, 32'h0));
    flows_pending.push_back(flow_beat({32'h420995bb, 32'ha18e6450, 16'h0aea, 16'h06e6}, '0));
    flows_pending.push_back(flow_beat({32'hc75c6f02, 32'h41458c53, 16'h3796, 16'h1283}, '0));
    flows_pending.push_back(flow_beat({3{32'haaaaaaaa}}, 32'h55555555));
    flows_pending.push_back(flow_beat({3{32'h55555555}}, 32'haaaaaaaa));
    flows_pending.push_back(flow_beat({64'h0, 32'hffffffff}, 32'h0));
    flows_pending.push_back(flow_beat({64'hffffffffffffffff, 32'h0}, 32'h0));
  endtask

  task automatic queue_random(input int count);
    logic [TUPLE_BITS-1:0] t;
    hash_t seed;
    for (int n = 0; n < count; n++) begin
      t    = {$urandom, $urandom, $urandom};
      seed = $urandom;
      case ($urandom_range(0, 9))
        6: begin
          t = '0;
          t[$urandom_range(0, TUPLE_BITS-1)] = 1'b1;
          t[$urandom_range(0, TUPLE_BITS-1)] = 1'b1;
        end
        7: begin
          t = '1;
          t[$urandom_range(0, TUPLE_BITS-1)] = 1'b0;
        end
        8:       t[31:0] = ($urandom_range(0, 1) == 1) ? '1 : '0;
        9:       seed = '0;
        default: ;
      endcase
      flows_pending.push_back(flow_beat(t, seed));
    end
  endtask

  initial begin
    logic [KEY_FLAT_W-1:0] key;
    for (int i = 0; i < KEY_REGS; i++) key_shadow[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // key straight out of reset
    @(negedge clk);
    queue_directed();
    queue_random(FLOWS_PER_KEY);
    wait_idle();

    for (int phase = 1; phase < 10; phase++) begin
      case (phase)
        1: key = {64'h6a42b73bbeac01fa, 64'h77cb2da38030f20c, 64'hd0ca2bcbae7b30b4,
                  64'h4167253d43a38fb0, 64'h6d5a56da255b0ec2};
        2: key = '1;
        3: key = {5{64'haaaaaaaaaaaaaaaa}} ^ {64'h0, {2{64'hffffffffffffffff, 64'h0}}};
        4: key = {{4{64'h0}}, 64'h8000000000000000};
        5: key = {64'h1, {4{64'h0}}};
        default: for (int w = 0; w < KEY_FLAT_W / 32; w++) key[32*w +: 32] = $urandom;
      endcase
      load_key(key);
      if (phase == 6) begin
        for (int i = KEY_REGS; i < ADDR_SLOTS; i++) apb_write(i, {$urandom, $urandom});
        check_key_regs();
      end
      @(negedge clk);
      if (phase == 1 || phase == 2) queue_directed();
      queue_random(FLOWS_PER_KEY);
      if (phase == 2) holds_asked++;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (hashes_due.size() != 0) begin
      report_mismatch("flows never hashed", 64'(hashes_due.size()), 64'(0));
    end
    $display("hashed %0d flows under %0d key settings with %0d register writes",
             flows_hashed, key_loads + 1, reg_writes);
    $display("stimulus: corner tuples, single-bit tuples, known rss vectors, random flows");
    if (errors == 0) begin
      $display("toeplitz_flow_hash regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("toeplitz_flow_hash regression: fail");
    end
    $finish;
  end

endmodule

@@ toeplitz_flow_hash.f @@
rtl/tfh_pkg.sv
rtl/tfh_hash_pipe.sv
rtl/toeplitz_flow_hash.sv
tb/tb_toeplitz_flow_hash.sv
